// ===== design/assert_macros.svh =====
// Assertion helpers used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that must also hold through reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/stip_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package stip_pkg;

  localparam int MAX_LEN = 4096;
  localparam int COUNT_W = $clog2(MAX_LEN + 1);

  localparam int VALUE_W = 64;
  localparam int BASE_W  = 6;
  localparam int CHAR_W  = 8;
  localparam int DIGIT_W = 7;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Register map, indexed by paddr[2].
  localparam logic REG_NUMBER_BASE = 1'b0;
  localparam logic REG_SIGNED_MODE = 1'b1;

  localparam logic [BASE_W-1:0] NUMBER_BASE_RST = 6'd10;
  localparam logic              SIGNED_MODE_RST = 1'b1;

  localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_W-1:0] BASE_MIN  = 6'd2;
  localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;
  localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_A_UP  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_X_UP  = 8'h58;
  localparam logic [CHAR_W-1:0] CH_Z_UP  = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_A_LO  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_X_LO  = 8'h78;
  localparam logic [CHAR_W-1:0] CH_Z_LO  = 8'h7A;

  localparam logic [DIGIT_W-1:0] DIGIT_NONE = 7'd99;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 7'd10;

  typedef enum logic [1:0] {
    ST_PARSED   = 2'd0,
    ST_EARLY    = 2'd1,
    ST_BAD_BASE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_BEGIN,
    PH_AFTER0,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [BASE_W-1:0] number_base;
    logic              signed_mode;
  } cfg_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] offset;
    status_t            status;
  } result_t;

  // Digit weight of a character, DIGIT_NONE for anything that is no digit.
  function automatic logic [DIGIT_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
    logic [DIGIT_W-1:0] d;
    begin
      d = DIGIT_NONE;
      if (c inside {[CH_ZERO:CH_NINE]}) begin
        d = DIGIT_W'(c - CH_ZERO);
      end else if (c inside {[CH_A_UP:CH_Z_UP]}) begin
        d = DIGIT_W'(c - CH_A_UP) + DIGIT_TEN;
      end else if (c inside {[CH_A_LO:CH_Z_LO]}) begin
        d = DIGIT_W'(c - CH_A_LO) + DIGIT_TEN;
      end
      return d;
    end
  endfunction

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
  endfunction

endpackage
`default_nettype wire

// ===== design/stip_char_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface stip_char_if;
  logic                         valid;
  logic                         ready;
  logic [stip_pkg::CHAR_W-1:0]  char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface
`default_nettype wire

// ===== design/stip_result_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface stip_result_if;
  logic                          valid;
  logic                          ready;
  logic [stip_pkg::VALUE_W-1:0]  parsed_value;
  logic [stip_pkg::COUNT_W-1:0]  stop_offset;
  logic [1:0]                    parse_status;

  modport source (output valid, output parsed_value, output stop_offset,
                  output parse_status, input ready);
  modport sink   (input valid, input parsed_value, input stop_offset,
                  input parse_status, output ready);
endinterface
`default_nettype wire

// ===== design/string_to_integer_parser_core.sv =====
// String-to-integer parser: feed the bytes of a NUL-terminated string on
// char_in, one per beat, and collect one result beat on result_out when the
// NUL arrives (parsed 64-bit value, offset of the first unparsed character
// saturating at MAX_LEN, and status 0 parsed / 1 ended early / 2 invalid
// base). The radix (number_base, register 0 at address 0, 2..36 or 0 for
// auto-detect) and signed_mode (register 1 at address 4) are sampled at the
// first character of each string. Save for the stall below, the block takes
// one character per clock: each character passes through an input
// register, then a single step of the parse state machine (one 64-by-6
// multiply-accumulate) into the state and, on NUL, the result register.
// The only stall is a NUL that meets a result still waiting to be taken;
// ordinary characters keep flowing.
`timescale 1ns / 1ps
`default_nettype none
module string_to_integer_parser_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  stip_char_if.sink                          char_in,
  stip_result_if.source                      result_out,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [stip_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [stip_pkg::PDATA_W-1:0]  pwdata,
  output logic      [stip_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready
);

  stip_pkg::cfg_t               cfg;
  stip_pkg::result_t            step_result;

  // input register
  logic                         hold_valid;
  logic [stip_pkg::CHAR_W-1:0]  hold_char;
  logic                         hold_nul;

  logic                         out_free;
  logic                         advance;
  logic                         in_beat;

  // result register
  logic                         out_valid;
  stip_pkg::result_t            out_data;

  stip_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  stip_parse_fsm u_fsm (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .char_code (hold_char),
    .cfg       (cfg),
    .result    (step_result)
  );

  assign hold_nul = (hold_char == stip_pkg::CH_NUL);

  // The result register is free if empty or being drained this cycle.
  assign out_free = !out_valid || result_out.ready;

  // Advance the held character unless it is a NUL that has nowhere to go.
  assign advance  = hold_valid && (!hold_nul || out_free);

  // Take a new beat whenever the input register empties this cycle.
  assign char_in.ready = !hold_valid || advance;
  assign in_beat       = char_in.valid && char_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_beat) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  // Payload of the input register carries no reset.
  always_ff @(posedge clk) begin
    if (in_beat) begin
      hold_char <= char_in.char_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && hold_nul) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Load the result only on the NUL step; hold it otherwise.
  always_ff @(posedge clk) begin
    if (advance && hold_nul) begin
      out_data <= step_result;
    end
  end

  assign result_out.valid        = out_valid;
  assign result_out.parsed_value = out_data.value;
  assign result_out.stop_offset  = out_data.offset;
  assign result_out.parse_status = out_data.status;

endmodule
`default_nettype wire

// ===== design/stip_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
module stip_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [stip_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [stip_pkg::PDATA_W-1:0]  pwdata,
  output logic      [stip_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready,
  output stip_pkg::cfg_t                     cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.number_base <= stip_pkg::NUMBER_BASE_RST;
      cfg.signed_mode <= stip_pkg::SIGNED_MODE_RST;
    end else if (wr_en) begin
      case (paddr[2])
        stip_pkg::REG_NUMBER_BASE: cfg.number_base <= pwdata[stip_pkg::BASE_W-1:0];
        stip_pkg::REG_SIGNED_MODE: cfg.signed_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      stip_pkg::REG_NUMBER_BASE:
        prdata = stip_pkg::PDATA_W'(cfg.number_base);
      stip_pkg::REG_SIGNED_MODE:
        prdata = stip_pkg::PDATA_W'(cfg.signed_mode);
      default:
        prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/stip_parse_fsm.sv =====
`timescale 1ns / 1ps
`default_nettype none
module stip_parse_fsm (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         step,
  input  wire logic [stip_pkg::CHAR_W-1:0]  char_code,
  input  wire stip_pkg::cfg_t               cfg,
  output stip_pkg::result_t                 result
);

  stip_pkg::phase_t                phase, phase_next;
  stip_pkg::status_t               early, early_next;
  logic [stip_pkg::VALUE_W-1:0]    acc, acc_next;
  logic                            neg, neg_next;
  logic [stip_pkg::COUNT_W-1:0]    char_count;
  logic [stip_pkg::BASE_W-1:0]     active_base, base_next;
  logic [stip_pkg::COUNT_W-1:0]    stop_pos, stop_next;
  logic                            latched_signed;

  logic                            first;
  logic                            sign_eff;
  logic                            is_nul;
  logic [stip_pkg::DIGIT_W-1:0]    digit;
  logic                            do_begin;
  logic                            do_take;

  assign first    = (char_count == '0);
  assign sign_eff = first ? cfg.signed_mode : latched_signed;
  assign is_nul   = (char_code == stip_pkg::CH_NUL);
  assign digit    = stip_pkg::digit_value(char_code);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= stip_pkg::PH_LEAD;
      early          <= stip_pkg::ST_PARSED;
      acc            <= '0;
      neg            <= 1'b0;
      char_count     <= '0;
      active_base    <= '0;
      stop_pos       <= '0;
      latched_signed <= 1'b0;
    end else if (step) begin
      if (is_nul) begin
        // string finished: clear for the next one
        phase          <= stip_pkg::PH_LEAD;
        early          <= stip_pkg::ST_PARSED;
        acc            <= '0;
        neg            <= 1'b0;
        char_count     <= '0;
        active_base    <= '0;
        stop_pos       <= '0;
        latched_signed <= 1'b0;
      end else begin
        phase          <= phase_next;
        early          <= early_next;
        acc            <= acc_next;
        neg            <= neg_next;
        active_base    <= base_next;
        stop_pos       <= stop_next;
        latched_signed <= sign_eff;
        if (char_count < stip_pkg::COUNT_W'(stip_pkg::MAX_LEN)) begin
          char_count <= char_count + 1'b1;
        end
      end
    end
  end

  always_comb begin
    phase_next = phase;
    early_next = early;
    acc_next   = acc;
    neg_next   = neg;
    base_next  = first ? cfg.number_base : active_base;
    stop_next  = stop_pos;
    do_begin   = 1'b0;
    do_take    = 1'b0;

    case (phase)
      stip_pkg::PH_LEAD: begin
        if (is_nul) begin
          early_next = stip_pkg::ST_EARLY;
          phase_next = stip_pkg::PH_DONE;
        end else if (sign_eff && stip_pkg::is_space(char_code)) begin
          phase_next = stip_pkg::PH_LEAD;
        end else if (sign_eff && (char_code == stip_pkg::CH_MINUS)) begin
          neg_next   = 1'b1;
          phase_next = stip_pkg::PH_BEGIN;
        end else begin
          do_begin = 1'b1;
        end
      end
      stip_pkg::PH_BEGIN: begin
        do_begin = 1'b1;
      end
      stip_pkg::PH_AFTER0: begin
        if (is_nul) begin
          early_next = stip_pkg::ST_EARLY;
          phase_next = stip_pkg::PH_DONE;
        end else if ((char_code == stip_pkg::CH_X_UP) || (char_code == stip_pkg::CH_X_LO)) begin
          base_next  = stip_pkg::BASE_HEX;
          phase_next = stip_pkg::PH_DIGITS;
        end else begin
          if (base_next == stip_pkg::BASE_AUTO) begin
            base_next = stip_pkg::BASE_OCT;
          end
          phase_next = stip_pkg::PH_DIGITS;
          do_take    = 1'b1;
        end
      end
      stip_pkg::PH_DIGITS: begin
        do_take = 1'b1;
      end
      default: ;
    endcase

    // start of the number proper: end early on NUL, pick or check the radix and handle a leading zero
    if (do_begin) begin
      if (is_nul) begin
        early_next = stip_pkg::ST_EARLY;
        phase_next = stip_pkg::PH_DONE;
      end else if ((base_next == stip_pkg::BASE_AUTO) || (base_next == stip_pkg::BASE_HEX)) begin
        if (char_code == stip_pkg::CH_ZERO) begin
          phase_next = stip_pkg::PH_AFTER0;
        end else begin
          if (base_next == stip_pkg::BASE_AUTO) begin
            base_next = stip_pkg::BASE_DEC;
          end
          phase_next = stip_pkg::PH_DIGITS;
          do_take    = 1'b1;
        end
      end else if ((base_next < stip_pkg::BASE_MIN) || (base_next > stip_pkg::BASE_MAX)) begin
        early_next = stip_pkg::ST_BAD_BASE;
        phase_next = stip_pkg::PH_DONE;
      end else begin
        phase_next = stip_pkg::PH_DIGITS;
        do_take    = 1'b1;
      end
    end

    // one multiply-accumulate, or stop at the first non-digit
    if (do_take) begin
      if (digit < stip_pkg::DIGIT_W'(base_next)) begin
        acc_next = acc * stip_pkg::VALUE_W'(base_next) + stip_pkg::VALUE_W'(digit);
      end else begin
        stop_next  = char_count;
        early_next = stip_pkg::ST_PARSED;
        phase_next = stip_pkg::PH_DONE;
      end
    end

    result.status = early_next;
    if (early_next == stip_pkg::ST_PARSED) begin
      result.value  = neg_next ? (stip_pkg::VALUE_W'(0) - acc_next) : acc_next;
      result.offset = stop_next;
    end else begin
      result.value  = '0;
      result.offset = '0;
    end
  end

endmodule
`default_nettype wire

// ===== design/stip_port_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module stip_port_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          res_valid,
  input wire logic                          res_ready,
  input wire logic [stip_pkg::VALUE_W-1:0]  parsed_value,
  input wire logic [stip_pkg::COUNT_W-1:0]  stop_offset,
  input wire logic [1:0]                    parse_status
);

  // A stalled result beat stays offered.
  `ASSERT_CLK(a_res_hold, clk, rst, (res_valid && !res_ready) |=> res_valid, "result beat dropped while stalled")

  // A stalled result beat keeps its payload.
  `ASSERT_CLK(a_res_stable, clk, rst, (res_valid && !res_ready) |=> ($stable(parsed_value) && $stable(stop_offset) && $stable(parse_status)), "result payload changed while stalled")

  // Only the three defined status codes appear.
  `ASSERT_CLK(a_status_code, clk, rst, res_valid |-> ((parse_status == stip_pkg::ST_PARSED) || (parse_status == stip_pkg::ST_EARLY) || (parse_status == stip_pkg::ST_BAD_BASE)), "undefined parse status")

  // Early end and invalid base give a zero value and a zero offset.
  `ASSERT_CLK(a_fail_zero, clk, rst, (res_valid && (parse_status != stip_pkg::ST_PARSED)) |-> ((parsed_value == '0) && (stop_offset == '0)), "failed parse carries a value")

  // The offset saturates at the maximum length.
  `ASSERT_CLK(a_offset_sat, clk, rst, res_valid |-> (stop_offset <= stip_pkg::COUNT_W'(stip_pkg::MAX_LEN)), "stop offset beyond maximum length")

endmodule

bind string_to_integer_parser_core stip_port_checker u_port_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (result_out.valid),
  .res_ready    (result_out.ready),
  .parsed_value (result_out.parsed_value),
  .stop_offset  (result_out.stop_offset),
  .parse_status (result_out.parse_status)
);
`default_nettype wire

// ===== bench/stip_parse_checker.sv =====
`timescale 1ns / 1ps
module stip_parse_checker
  import stip_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  stip_char_if                chars,
  stip_result_if              results,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output int unsigned         awaiting,
  output int unsigned         fault_count
);

  cfg_t               regs;
  phase_t             ph;
  logic [VALUE_W-1:0] acc;
  logic               neg;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] stop_at;
  logic [BASE_W-1:0]  radix;
  logic               signed_now;
  status_t            early;

  result_t            pending_results[$];
  result_t            want;
  bit                 emitted;
  int unsigned        faults;

  function automatic logic [DIGIT_W-1:0] weight_of(input logic [CHAR_W-1:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return DIGIT_W'(c - CH_ZERO);
    if (c >= CH_A_UP && c <= CH_Z_UP) return DIGIT_W'(c - CH_A_UP) + DIGIT_TEN;
    if (c >= CH_A_LO && c <= CH_Z_LO) return DIGIT_W'(c - CH_A_LO) + DIGIT_TEN;
    return DIGIT_NONE;
  endfunction

  function automatic bit blank_char(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  task automatic clear_string();
    ph         = PH_LEAD;
    acc        = '0;
    neg        = 1'b0;
    count      = '0;
    stop_at    = '0;
    radix      = '0;
    signed_now = 1'b0;
    early      = ST_PARSED;
  endtask

  task automatic close_early(input status_t s);
    early = s;
    ph    = PH_DONE;
  endtask

  // Fold one digit in, or freeze the stop offset at the first non-digit.
  task automatic accumulate(input logic [CHAR_W-1:0] c);
    logic [DIGIT_W-1:0] w;
    w = weight_of(c);
    if (w < DIGIT_W'(radix)) begin
      acc = acc * VALUE_W'(radix) + VALUE_W'(w);
    end else begin
      stop_at = count;
      early   = ST_PARSED;
      ph      = PH_DONE;
    end
  endtask

  task automatic start_number(input logic [CHAR_W-1:0] c);
    if (c == CH_NUL) begin
      close_early(ST_EARLY);
    end else if (radix == BASE_AUTO || radix == BASE_HEX) begin
      if (c == CH_ZERO) begin
        ph = PH_AFTER0;
      end else begin
        if (radix == BASE_AUTO) radix = BASE_DEC;
        ph = PH_DIGITS;
        accumulate(c);
      end
    end else if (radix < BASE_MIN || radix > BASE_MAX) begin
      close_early(ST_BAD_BASE);
    end else begin
      ph = PH_DIGITS;
      accumulate(c);
    end
  endtask

  task automatic parse_char(input logic [CHAR_W-1:0] c, output bit done, output result_t r);
    case (ph)
      PH_LEAD: begin
        if (count == '0) begin
          signed_now = regs.signed_mode;
          radix      = regs.number_base;
        end
        if (c == CH_NUL) begin
          close_early(ST_EARLY);
        end else if (signed_now && blank_char(c)) begin
          // hold in the leading phase
        end else if (signed_now && c == CH_MINUS) begin
          neg = 1'b1;
          ph  = PH_BEGIN;
        end else begin
          start_number(c);
        end
      end
      PH_BEGIN: start_number(c);
      PH_AFTER0: begin
        if (c == CH_NUL) begin
          close_early(ST_EARLY);
        end else if (c == CH_X_LO || c == CH_X_UP) begin
          radix = BASE_HEX;
          ph    = PH_DIGITS;
        end else begin
          if (radix == BASE_AUTO) radix = BASE_OCT;
          ph = PH_DIGITS;
          accumulate(c);
        end
      end
      PH_DIGITS: accumulate(c);
      default: ;
    endcase

    r = '0;
    done = (c == CH_NUL);
    if (done) begin
      if (early == ST_PARSED) begin
        r.value  = neg ? (VALUE_W'(0) - acc) : acc;
        r.offset = stop_at;
      end
      r.status = early;
      clear_string();
    end else if (count < COUNT_W'(MAX_LEN)) begin
      count = count + 1'b1;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      regs.number_base = NUMBER_BASE_RST;
      regs.signed_mode = SIGNED_MODE_RST;
      clear_string();
      pending_results.delete();
      faults = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_NUMBER_BASE) regs.number_base = pwdata[BASE_W-1:0];
        else regs.signed_mode = pwdata[0];
      end
      if (chars.valid && chars.ready) begin
        parse_char(chars.char_code, emitted, want);
        if (emitted) pending_results.push_back(want);
      end
      if (results.valid && results.ready) begin
        if (pending_results.size() == 0) begin
          $error("result beat with no string pending: parsed_value %h", results.parsed_value);
          faults++;
        end else begin
          want = pending_results.pop_front();
          if (results.parsed_value !== want.value) begin
            $error("parsed_value: expected %h, got %h", want.value, results.parsed_value);
            faults++;
          end
          if (results.stop_offset !== want.offset) begin
            $error("stop_offset: expected %0d, got %0d", want.offset, results.stop_offset);
            faults++;
          end
          if (results.parse_status !== want.status) begin
            $error("parse_status: expected %0d, got %0d", want.status, results.parse_status);
            faults++;
          end
        end
      end
    end
    awaiting    <= pending_results.size();
    fault_count <= faults;
  end

endmodule

// ===== bench/tb_string_to_integer_parser_core.sv =====
`timescale 1ns / 1ps
module tb_string_to_integer_parser_core;
  import stip_pkg::*;

  // Generous ceiling on the length of a run.
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          LONG_HOLD   = 400;
  localparam int          PHASE_CHARS = 140;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  stip_char_if   char_bus ();
  stip_result_if res_bus ();

  int unsigned awaiting;
  int unsigned fault_count;
  int unsigned cycle_count = 0;

  // Idle percentages per clock for each side, set per phase of the run.
  int          tx_idle = 0;
  int          rx_idle = 0;
  logic        stall_req;
  logic        stall_seen;
  int          hold_left;

  // Register values most recently written; the radix shapes the random strings.
  logic [BASE_W-1:0] cur_base = NUMBER_BASE_RST;
  logic              cur_signed = SIGNED_MODE_RST;

  logic [CHAR_W-1:0] str_q[$];
  int unsigned       sent_chars = 0;

  string_to_integer_parser_core uut (
    .clk        (clk),
    .rst        (rst),
    .char_in    (char_bus),
    .result_out (res_bus),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  stip_parse_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .chars       (char_bus),
    .results     (res_bus),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .awaiting    (awaiting),
    .fault_count (fault_count)
  );

  always #2 clk = ~clk;

  // Abort a run that hangs: a lost result or a wedged handshake lands here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side. Drop ready at random per the current idle rate; on request,
  // hold it low for one long stretch so that the block backs up onto its input.
  always @(posedge clk) begin
    if (rst) begin
      res_bus.ready <= 1'b0;
      hold_left     <= 0;
      stall_seen    <= 1'b0;
    end else if (stall_req && !stall_seen) begin
      stall_seen    <= 1'b1;
      hold_left     <= LONG_HOLD;
      res_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  // Offer one character, with random idle cycles ahead of it, and hold it
  // until the beat is taken. Returns in the time step of the accepting edge.
  task automatic send_char(input logic [CHAR_W-1:0] c);
    while ($urandom_range(99) < tx_idle) begin
      char_bus.valid <= 1'b0;
      @(posedge clk);
    end
    char_bus.valid     <= 1'b1;
    char_bus.char_code <= c;
    @(posedge clk);
    while (!char_bus.ready) @(posedge clk);
  endtask

  task automatic add_text(input string t);
    for (int i = 0; i < t.len(); i++) str_q.push_back(t[i]);
  endtask

  // Send the built-up string followed by its terminating NUL.
  task automatic send_str();
    str_q.push_back(CH_NUL);
    foreach (str_q[i]) send_char(str_q[i]);
    sent_chars += str_q.size();
    str_q.delete();
  endtask

  // Drop valid and wait until every outstanding result has been collected,
  // then let the input and result registers settle.
  task automatic wait_results_clear();
    char_bus.valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Setup then access cycle; psel stays high when a second write follows.
  task automatic apb_beat(input logic [PADDR_W-1:0] a, input logic [PDATA_W-1:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  // Write both registers with the block idle. Upper data bits are random
  // junk that the block must ignore.
  task automatic configure(input logic [BASE_W-1:0] b, input logic s);
    logic [PDATA_W-1:0] junk;
    wait_results_clear();
    junk = $urandom;
    apb_beat({REG_NUMBER_BASE, 2'b00}, {junk[PDATA_W-1:BASE_W], b});
    junk = $urandom;
    apb_beat({REG_SIGNED_MODE, 2'b00}, {junk[PDATA_W-1:1], s});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_base   = b;
    cur_signed = s;
  endtask

  // Random digit of radix b, letters in either case.
  function automatic logic [CHAR_W-1:0] digit_char(input int b);
    int d;
    d = $urandom_range(b - 1);
    if (d < 10) return CHAR_W'(CH_ZERO + d);
    return CHAR_W'(($urandom_range(1) ? CH_A_UP : CH_A_LO) + d - 10);
  endfunction

  // Mostly well-formed numbers (blanks, sign, prefix, digits, tail) with
  // random content; the rest is plain byte noise.
  task automatic random_string();
    int b;
    int n;
    if (cur_base >= BASE_MIN && cur_base <= BASE_MAX) b = cur_base;
    else b = $urandom_range(1) ? BASE_HEX : BASE_DEC;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(8)) str_q.push_back(CHAR_W'($urandom_range(1, 255)));
    end else begin
      repeat ($urandom_range(3)) begin
        if ($urandom_range(1)) str_q.push_back(CH_SPACE);
        else str_q.push_back(CHAR_W'($urandom_range(CH_TAB, CH_CR)));
      end
      if ($urandom_range(3) == 0) str_q.push_back(CH_MINUS);
      case ($urandom_range(3))
        0: begin
          str_q.push_back(CH_ZERO);
          str_q.push_back($urandom_range(1) ? CH_X_LO : CH_X_UP);
        end
        1: str_q.push_back(CH_ZERO);
        default: ;
      endcase
      // Now and then run long enough to wrap the 64-bit value in the larger radixes.
      n = ($urandom_range(3) == 0) ? $urandom_range(14, 26) : $urandom_range(8);
      repeat (n) str_q.push_back(digit_char(b));
      if ($urandom_range(1)) begin
        repeat ($urandom_range(1, 3)) str_q.push_back(CHAR_W'($urandom_range(1, 255)));
      end
    end
    send_str();
  endtask

  function automatic logic [BASE_W-1:0] phase_base(input int p);
    case (p)
      0:  return BASE_AUTO;
      1:  return BASE_DEC;
      2:  return BASE_HEX;
      3:  return BASE_W'($urandom_range(BASE_MIN, BASE_MAX));
      4:  return BASE_MIN;
      5:  return BASE_MAX;
      6:  return BASE_OCT;
      7:  return BASE_W'(1);
      8:  return BASE_W'($urandom_range(BASE_MAX + 1, 63));
      9:  return BASE_AUTO;
      10: return BASE_HEX;
      default: return BASE_W'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned goal;

    char_bus.valid     <= 1'b0;
    char_bus.char_code <= CH_NUL;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    stall_req          <= 1'b0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed strings: sender idles lightly, receiver heavily.
    tx_idle = 11;
    rx_idle = 84;

    configure(BASE_DEC, 1'b1);
    add_text("  -42x"); send_str();              // blanks, sign, stop on a letter
    send_str();                                  // empty string ends early
    str_q.push_back(CH_TAB);
    str_q.push_back(CH_MINUS); send_str();       // lone minus ends early
    add_text("1");
    str_q.push_back(8'hFF);
    str_q.push_back(8'h80); send_str();          // top-bit bytes after the number
    add_text("18446744073709551617"); send_str(); // wraps past 2^64

    configure(BASE_AUTO, 1'b1);
    add_text("0x1F"); send_str();                // auto radix picks hex
    add_text("017"); send_str();                 // auto radix picks octal
    add_text("0"); send_str();                   // lone zero ends early
    add_text("0x"); send_str();                  // prefix with no digits
    add_text("-0X7g"); send_str();
    add_text("99"); send_str();

    configure(BASE_HEX, 1'b0);
    add_text("0XfF"); send_str();                // optional prefix skipped
    add_text(" 5"); send_str();                  // blanks not skipped when unsigned
    add_text("-1"); send_str();                  // no sign when unsigned
    add_text("0"); send_str();

    configure(BASE_W'(1), 1'b1);
    add_text("7"); send_str();                   // invalid radix
    send_str();

    configure(BASE_W'(63), 1'b0);
    add_text("Z"); send_str();

    configure(BASE_MIN, 1'b0);
    add_text("1012"); send_str();

    configure(BASE_MAX, 1'b1);
    add_text("zZ9"); send_str();
    add_text("-ZZZZZZZZZZZZZZ"); send_str();

    // Random phases, walking through the idle patterns in thirds.
    for (int p = 0; p < 12; p++) begin
      configure(phase_base(p), (p % 2) == 0);
      tx_idle = (p < 4) ? 11 : (p < 8) ? 84 : 0;
      rx_idle = (p < 4) ? 84 : (p < 8) ? 11 : 0;
      if (p == 8) begin
        // Hold the receiver off while short strings keep coming, so the
        // result register fills and the block stalls its input on a NUL.
        stall_req <= 1'b1;
        repeat (12) begin
          add_text("5");
          send_str();
        end
      end
      goal = sent_chars + PHASE_CHARS;
      while (sent_chars < goal) random_string();
    end

    wait_results_clear();
    repeat (8) @(posedge clk);
    if (fault_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/stip_pkg.sv
design/stip_char_if.sv
design/stip_result_if.sv
design/stip_cfg_regs.sv
design/stip_parse_fsm.sv
design/string_to_integer_parser_core.sv
design/stip_port_checker.sv
bench/stip_parse_checker.sv
bench/tb_string_to_integer_parser_core.sv
